// ===== src/dial_set_countdown_relay_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dial-set countdown relay timer
// Assertion checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DIAL_SET_COUNTDOWN_RELAY_TIMER_DEFINES_SVH
`define DIAL_SET_COUNTDOWN_RELAY_TIMER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define DSCRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dscrt: same-cycle check failed");

// next-cycle implication
`define DSCRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dscrt: next-cycle check failed");

`else

`define DSCRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DSCRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/dscrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dscrt_pkg
// Shared widths, register map, reset values and pipeline control type.
// ----------------------------------------------------------------------------
package dscrt_pkg;

	localparam int ADC_W     = 8;
	localparam int MIN_W     = 9;
	localparam int PRESC_W   = 16;
	localparam int HB_W      = 8;
	localparam int SUM_W     = 10;
	localparam int PROD_W    = ADC_W + MIN_W;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	// avg = (sum * 683) >> 11, exact for sums below 2048
	localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
	localparam int               DIV3_SHIFT = 11;

	localparam logic [PRESC_W-1:0] RST_TICKS_PER_MIN = 16'd7200;
	localparam logic [HB_W-1:0]    RST_LED_TICKS     = 8'd50;
	localparam logic [MIN_W-1:0]   RST_RELOAD_BAND   = 9'd10;
	localparam logic [MIN_W-1:0]   RST_FULL_SCALE    = 9'd300;
	localparam logic [MIN_W-1:0]   RST_RELAY_FLOOR   = 9'd10;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TICKS_PER_MIN = 3'd0,
		REG_LED_TICKS     = 3'd1,
		REG_RELOAD_BAND   = 3'd2,
		REG_FULL_SCALE    = 3'd3,
		REG_RELAY_FLOOR   = 3'd4
	} dscrt_reg_t;

	typedef struct packed {
		logic tick_fire; // input transfer this cycle
		logic adv_s1;    // stage 1 moves into stage 2
	} dscrt_pipe_ctrl_t;

endpackage

// ===== src/dscrt_dial_filter.sv =====
// ----------------------------------------------------------------------------
// dscrt_dial_filter
// Three-sample moving average of the dial and scaling to minutes.
// Stage 1 holds the average, stage 2 the product with the full scale;
// the divide by 255 on stage 2 is a reciprocal multiply with one correction.
// ----------------------------------------------------------------------------
module dscrt_dial_filter
	import dscrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dscrt_pipe_ctrl_t   ctrl,
	input  logic [ADC_W-1:0]   adc_sample,
	input  logic [MIN_W-1:0]   full_scale,
	output logic [MIN_W-1:0]   setting
);

	logic [ADC_W-1:0]        hist_q [2];
	logic [SUM_W-1:0]        sum;
	logic [2*SUM_W-1:0]      sum_scaled;
	logic [ADC_W-1:0]        avg_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic [PROD_W+HB_W-1:0]  prod_x257;
	logic [MIN_W-1:0]        quot_est;
	logic [PROD_W-1:0]       quot_x255;
	logic [PROD_W-1:0]       rem;

	assign sum = SUM_W'(adc_sample) + SUM_W'(hist_q[0]) + SUM_W'(hist_q[1]);
	assign sum_scaled = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
		end else if (ctrl.tick_fire) begin
			hist_q[0] <= adc_sample;
			hist_q[1] <= hist_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tick_fire) begin
			avg_s1 <= sum_scaled[DIV3_SHIFT +: ADC_W];
		end
		if (ctrl.adv_s1) begin
			prod_s2 <= PROD_W'(avg_s1) * PROD_W'(full_scale);
		end
	end

	// x/255 ~ x*257 >> 16, low by at most one
	assign prod_x257 = (PROD_W+HB_W)'(prod_s2) + ((PROD_W+HB_W)'(prod_s2) << HB_W);
	assign quot_est  = prod_x257[PROD_W+HB_W-1:PROD_W+HB_W-MIN_W];
	assign quot_x255 = (PROD_W'(quot_est) << HB_W) - PROD_W'(quot_est);
	assign rem       = prod_s2 - quot_x255;
	assign setting   = (rem >= PROD_W'(255)) ? quot_est + MIN_W'(1) : quot_est;

endmodule

// ===== src/dial_set_countdown_relay_timer.sv =====
// ----------------------------------------------------------------------------
// dial_set_countdown_relay_timer
// Tick-driven countdown relay timer set by a filtered dial reading.
// ----------------------------------------------------------------------------
//  channel | signals                                         | role
//  tick    | tick_valid, tick_ready, adc_sample              | one tick, dial sample
//  result  | result_valid, result_ready, relay_on, led_state,| one result per tick
//          | minutes_left, dial_minutes                      |
//  config  | psel, penable, pwrite, paddr, pwdata, prdata,   | APB register port
//          | pready                                          |
//
//  One tick per cycle while results are taken; a tick's result passes the average
//  register, the multiply register, then the state/result register, where it is valid.
//  The state update stage closes all counters for a tick in one combinational
//  step and takes the next tick as soon as its result register can be loaded.
//  Async reset returns valids, timer state and config to defaults, not data regs.
//  A stalled result holds its register; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
`include "dial_set_countdown_relay_timer_defines.svh"

module dial_set_countdown_relay_timer
	import dscrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic [ADC_W-1:0]  adc_sample,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              relay_on,
	output logic              led_state,
	output logic [MIN_W-1:0]  minutes_left,
	output logic [MIN_W-1:0]  dial_minutes,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// configuration
	logic [PRESC_W-1:0] tpm_q;
	logic [HB_W-1:0]    led_ticks_q;
	logic [MIN_W-1:0]   band_q;
	logic [MIN_W-1:0]   full_scale_q;
	logic [MIN_W-1:0]   floor_q;
	dscrt_reg_t         reg_idx;
	logic               cfg_wr;

	// pipeline control
	logic             v1_q, v2_q, res_valid_q;
	logic             ready_s1, ready_s2, commit;
	dscrt_pipe_ctrl_t ctrl;
	logic [MIN_W-1:0] setting;

	// timer state
	logic [HB_W-1:0]    hb_q, hb_n, hb_inc;
	logic               led_q, led_n;
	logic [PRESC_W-1:0] presc_q, presc_n, presc_inc;
	logic               flag_q, flag_n;
	logic [MIN_W-1:0]   cd_q, cd_n, cd_ld;
	logic [MIN_W-1:0]   saved_q, saved_n;
	logic [PRESC_W-1:0] lo, hi, saved_ext;
	logic               reload, relay;

	// result register
	logic               res_relay_q;
	logic               res_led_q;
	logic [MIN_W-1:0]   res_minutes_q;
	logic [MIN_W-1:0]   res_dial_q;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = dscrt_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q        <= RST_TICKS_PER_MIN;
			led_ticks_q  <= RST_LED_TICKS;
			band_q       <= RST_RELOAD_BAND;
			full_scale_q <= RST_FULL_SCALE;
			floor_q      <= RST_RELAY_FLOOR;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TICKS_PER_MIN: tpm_q        <= pwdata[PRESC_W-1:0];
				REG_LED_TICKS:     led_ticks_q  <= pwdata[HB_W-1:0];
				REG_RELOAD_BAND:   band_q       <= pwdata[MIN_W-1:0];
				REG_FULL_SCALE:    full_scale_q <= pwdata[MIN_W-1:0];
				REG_RELAY_FLOOR:   floor_q      <= pwdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TICKS_PER_MIN: prdata = DATA_W'(tpm_q);
			REG_LED_TICKS:     prdata = DATA_W'(led_ticks_q);
			REG_RELOAD_BAND:   prdata = DATA_W'(band_q);
			REG_FULL_SCALE:    prdata = DATA_W'(full_scale_q);
			REG_RELAY_FLOOR:   prdata = DATA_W'(floor_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	assign ready_s2   = !res_valid_q || result_ready;
	assign ready_s1   = !v2_q || ready_s2;
	assign tick_ready = !v1_q || ready_s1;
	assign commit     = v2_q && ready_s2;

	assign ctrl.tick_fire = tick_valid && tick_ready;
	assign ctrl.adv_s1    = v1_q && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick_ready) v1_q        <= tick_valid;
			if (ready_s1)   v2_q        <= v1_q;
			if (ready_s2)   res_valid_q <= v2_q;
		end
	end

	dscrt_dial_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.adc_sample (adc_sample),
		.full_scale (full_scale_q),
		.setting    (setting)
	);

	// ---------------- per-tick state update ----------------
	assign lo        = PRESC_W'(setting) - PRESC_W'(band_q);
	assign hi        = PRESC_W'(setting) + PRESC_W'(band_q);
	assign saved_ext = PRESC_W'(saved_q);
	assign reload    = (saved_ext < lo) || (saved_ext > hi);

	always_comb begin
		hb_inc = hb_q + HB_W'(1);
		hb_n   = hb_inc;
		led_n  = led_q;
		if (hb_inc > led_ticks_q) begin
			hb_n  = '0;
			led_n = !led_q;
		end

		saved_n   = reload ? setting : saved_q;
		cd_ld     = reload ? setting : cd_q;
		presc_inc = (reload ? '0 : presc_q) + PRESC_W'(1);
		presc_n   = presc_inc;
		flag_n    = flag_q;
		if (presc_inc > tpm_q) begin
			presc_n = '0;
			flag_n  = 1'b1;
		end

		// relay state is taken before the minute decrement
		relay = cd_ld > floor_q;
		cd_n  = cd_ld;
		if (relay && flag_n) begin
			flag_n = 1'b0;
			cd_n   = cd_ld - MIN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q    <= '0;
			led_q   <= 1'b0;
			presc_q <= '0;
			flag_q  <= 1'b0;
			cd_q    <= '0;
			saved_q <= '0;
		end else if (commit) begin
			hb_q    <= hb_n;
			led_q   <= led_n;
			presc_q <= presc_n;
			flag_q  <= flag_n;
			cd_q    <= cd_n;
			saved_q <= saved_n;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_relay_q   <= relay;
			res_led_q     <= led_n;
			res_minutes_q <= cd_n;
			res_dial_q    <= setting;
		end
	end

	assign result_valid = res_valid_q;
	assign relay_on     = res_relay_q;
	assign led_state    = res_led_q;
	assign minutes_left = res_minutes_q;
	assign dial_minutes = res_dial_q;

	// ---------------- checks ----------------
	`DSCRT_ASSERT_NEXT(a_led_toggle_clears_count, clk, arst_n, commit, (led_q == $past(led_q)) || (hb_q == '0))
	`DSCRT_ASSERT_NOW(a_flag_taken_only_with_relay, clk, arst_n, $fell(flag_q), res_relay_q)
	`DSCRT_ASSERT_NEXT(a_countdown_single_step, clk, arst_n, commit && !reload, (cd_q == $past(cd_q)) || (cd_q == $past(cd_q) - MIN_W'(1)))
	`DSCRT_ASSERT_NEXT(a_relay_implies_above_floor, clk, arst_n, commit, !res_relay_q || (res_minutes_q >= floor_q))

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: dial-set countdown relay timer testbench
// Drives dial ticks through valid/ready with bursty sender and stalling
// receiver, predicts results from a local model of the timer or typed directed rows and checks
// each result transfer in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
	import dscrt_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic             relay;
		logic             led;
		logic [MIN_W-1:0] minutes;
		logic [MIN_W-1:0] dial;
	} timer_result_t;

	typedef struct {
		logic [ADC_W-1:0] sample;
		bit               typed;
		timer_result_t    res;
	} dial_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              tick_valid = 1'b0;
	logic              tick_ready;
	logic [ADC_W-1:0]  adc_sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic              relay_on;
	logic              led_state;
	logic [MIN_W-1:0]  minutes_left;
	logic [MIN_W-1:0]  dial_minutes;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	dial_set_countdown_relay_timer DUT (.*);

	// register shadow
	logic [PRESC_W-1:0] cfg_ticks_per_min = RST_TICKS_PER_MIN;
	logic [HB_W-1:0]    cfg_led_ticks     = RST_LED_TICKS;
	logic [MIN_W-1:0]   cfg_band          = RST_RELOAD_BAND;
	logic [MIN_W-1:0]   cfg_full_scale    = RST_FULL_SCALE;
	logic [MIN_W-1:0]   cfg_floor         = RST_RELAY_FLOOR;

	// timer state
	logic [ADC_W-1:0]   hist [3] = '{8'd0, 8'd0, 8'd0};
	logic [PRESC_W-1:0] presc = '0;
	logic               min_flag = 1'b0;
	logic [MIN_W-1:0]   count_left = '0;
	logic [MIN_W-1:0]   saved_set = '0;
	logic [HB_W-1:0]    hb_count = '0;
	logic               led_lvl = 1'b0;

	timer_result_t expected_results [$];
	dial_row_t     directed_rows [$];
	int            mismatch_count = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;
	bit            steady = 1'b0;
	int            hold_left = 0;
	logic [7:0]    hold_val = '0;
	bit            noisy = 1'b0;
	logic [15:0]   ready_pat = 16'hffff;
	int            pat_age = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic timer_result_t timer_tick(input logic [ADC_W-1:0] sample);
		logic [SUM_W-1:0]   sum;
		logic [ADC_W-1:0]   avg;
		logic [PROD_W-1:0]  prod;
		logic [MIN_W-1:0]   setting;
		logic [15:0]        lo;
		logic [15:0]        hi;
		logic               relay;
		timer_result_t      r;
		hb_count = hb_count + 8'd1;
		if (hb_count > cfg_led_ticks) begin
			hb_count = '0;
			led_lvl = ~led_lvl;
		end
		hist[2] = hist[1];
		hist[1] = hist[0];
		hist[0] = sample;
		sum = SUM_W'(hist[0]) + SUM_W'(hist[1]) + SUM_W'(hist[2]);
		avg = ADC_W'(sum / 10'd3);
		prod = PROD_W'(avg) * PROD_W'(cfg_full_scale);
		setting = MIN_W'(prod / 17'd255);
		// 16-bit wrap: a band wider than the setting reloads every tick
		lo = 16'(setting) - 16'(cfg_band);
		hi = 16'(setting) + 16'(cfg_band);
		if (saved_set < lo || saved_set > hi) begin
			saved_set = setting;
			count_left = setting;
			presc = '0;
		end
		presc = presc + 16'd1;
		if (presc > cfg_ticks_per_min) begin
			presc = '0;
			min_flag = 1'b1;
		end
		relay = count_left > cfg_floor;
		if (relay && min_flag) begin
			min_flag = 1'b0;
			count_left = count_left - 9'd1;
		end
		r.relay = relay;
		r.led = led_lvl;
		r.minutes = count_left;
		r.dial = setting;
		return r;
	endfunction

	// mostly held dial positions with small jitter, some bursts of noise
	function automatic logic [ADC_W-1:0] next_dial_sample();
		int v;
		if (hold_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				noisy = 1'b1;
				hold_left = $urandom_range(1, 4);
			end else begin
				noisy = 1'b0;
				hold_left = $urandom_range(5, 60);
				hold_val = 8'($urandom_range(0, 255));
			end
		end
		hold_left--;
		if (noisy)
			return 8'($urandom_range(0, 255));
		v = int'(hold_val) + $urandom_range(0, 2) - 1;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	task automatic add_row(input logic [7:0] sample, input bit typed, input logic relay,
			input logic led, input logic [8:0] minutes, input logic [8:0] dial);
		dial_row_t row;
		row.sample = sample;
		row.typed = typed;
		row.res = '{relay, led, minutes, dial};
		directed_rows.push_back(row);
	endtask

	task automatic send_tick(input logic [ADC_W-1:0] sample, input bit typed,
			input timer_result_t typed_res);
		int gap;
		timer_result_t pred;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tick_valid <= 1'b1;
		adc_sample <= sample;
		do @(posedge clk); while (!tick_ready);
		pred = timer_tick(sample);
		expected_results.push_back(typed ? typed_res : pred);
		burst_left--;
	endtask

	task automatic write_reg(input dscrt_reg_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TICKS_PER_MIN: cfg_ticks_per_min = value[PRESC_W-1:0];
			REG_LED_TICKS:     cfg_led_ticks = value[HB_W-1:0];
			REG_RELOAD_BAND:   cfg_band = value[MIN_W-1:0];
			REG_FULL_SCALE:    cfg_full_scale = value[MIN_W-1:0];
			REG_RELAY_FLOOR:   cfg_floor = value[MIN_W-1:0];
			default: ;
		endcase
		// read back right away
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== value) begin
			if (mismatch_count < 10)
				$display("readback reg %s: expected %0d, got %0d", idx.name(), value, rd);
			mismatch_count++;
		end
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: checks result transfers, stalls on a rotating pattern
	always @(posedge clk) begin
		timer_result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: relay %0b led %0b minutes %0d dial %0d",
						relay_on, led_state, minutes_left, dial_minutes);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (relay_on !== exp_r.relay || led_state !== exp_r.led ||
						minutes_left !== exp_r.minutes || dial_minutes !== exp_r.dial) begin
					if (mismatch_count < 10)
						$display("result mismatch: expected relay %0b led %0b minutes %0d dial %0d, got relay %0b led %0b minutes %0d dial %0d",
							exp_r.relay, exp_r.led, exp_r.minutes, exp_r.dial,
							relay_on, led_state, minutes_left, dial_minutes);
					mismatch_count++;
				end
			end
		end
		if (pat_age == 63) begin
			pat_age <= 0;
			ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
		end else begin
			pat_age <= pat_age + 1;
			ready_pat <= {ready_pat[0], ready_pat[15:1]};
		end
		result_ready <= ready_pat[0];
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && tick_ready) || (result_valid && result_ready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		timer_result_t none;
		logic [15:0] tpm;
		logic [7:0]  led;
		logic [8:0]  band;
		logic [8:0]  fs;
		logic [8:0]  floor_v;
		int          n_items;
		none = '0;

		// reset config; first rows read straight off the scaling
		add_row(8'd0,   1'b1, 1'b0, 1'b0, 9'd0,   9'd0);
		add_row(8'd255, 1'b1, 1'b1, 1'b0, 9'd100, 9'd100);
		add_row(8'd255, 1'b1, 1'b1, 1'b0, 9'd200, 9'd200);
		add_row(8'd255, 1'b1, 1'b1, 1'b0, 9'd300, 9'd300);
		add_row(8'd255, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd128, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd128, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd128, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd1,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd254, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd85,  1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd170, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd255, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd255, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd255, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd3,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd3,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
		add_row(8'd3,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_tick(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].res);

		for (int ph = 0; ph < 8; ph++) begin
			tick_valid <= 1'b0;
			burst_left = 0;
			wait_idle();
			n_items = 40;
			case (ph)
				0: begin tpm = 16'd1;     led = 8'd1;   band = 9'd0;   fs = 9'd300; floor_v = 9'd0;   end
				// band above any setting, relay held off so the minute flag sticks,
				// long enough for the heartbeat to wrap at its top limit
				1: begin tpm = 16'd2;     led = 8'd255; band = 9'd300; fs = 9'd1;   floor_v = 9'd300;
					n_items = 260; end
				2: begin tpm = 16'd65535; led = 8'd128; band = 9'd5;   fs = 9'd300; floor_v = 9'd10;  end
				3: begin tpm = 16'd3;     led = 8'd20;  band = 9'd20;  fs = 9'd150; floor_v = 9'd50;  end
				4: begin tpm = 16'd1;     led = 8'd254; band = 9'd0;   fs = 9'd255; floor_v = 9'd299; end
				default: begin
					tpm = ($urandom_range(0, 7) == 0) ? 16'd65535 : 16'($urandom_range(1, 40));
					led = 8'($urandom_range(1, 255));
					band = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 300))
						: 9'($urandom_range(0, 25));
					fs = 9'($urandom_range(1, 300));
					floor_v = 9'($urandom_range(0, 80));
				end
			endcase
			write_reg(REG_TICKS_PER_MIN, DATA_W'(tpm));
			write_reg(REG_LED_TICKS, DATA_W'(led));
			write_reg(REG_RELOAD_BAND, DATA_W'(band));
			write_reg(REG_FULL_SCALE, DATA_W'(fs));
			write_reg(REG_RELAY_FLOOR, DATA_W'(floor_v));
			steady = ($urandom_range(0, 3) == 0);
			repeat (n_items)
				send_tick(next_dial_sample(), 1'b0, none);
		end

		tick_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
